// ----- design/kbc_pkg.sv -----
// Package for the keyboard line to braille cell block.
// Holds command codes, key codes, line sizes and the braille lookup functions.
// No dependencies.
`default_nettype none

package kbc_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_KEY     = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_RETURN  = 2'd2;

    // Keyboard usage codes
    localparam logic [7:0] KEY_A_CODE     = 8'h04;
    localparam logic [7:0] KEY_Z_CODE     = 8'h1D;
    localparam logic [7:0] KEY_1_CODE     = 8'h1E;
    localparam logic [7:0] KEY_9_CODE     = 8'h26;
    localparam logic [7:0] KEY_0_CODE     = 8'h27;
    localparam logic [7:0] KEY_ENTER_CODE = 8'h28;
    localparam logic [7:0] KEY_BKSP_CODE  = 8'h2A;
    localparam logic [7:0] KEY_SPACE_CODE = 8'h2C;

    // ASCII
    localparam logic [6:0] CH_NONE  = 7'h00;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ONE   = 7'h31;
    localparam logic [6:0] CH_NINE  = 7'h39;
    localparam logic [6:0] CH_LC_A  = 7'h61;
    localparam logic [6:0] CH_LC_Z  = 7'h7A;

    // Line sizes: two banks of 128 characters, edit line capacity 127
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned ADDR_W   = COUNT_W + 1;
    localparam int unsigned MEM_DEPTH = 2 ** ADDR_W;
    localparam logic [COUNT_W-1:0] CAPACITY = 7'd127;

    localparam int unsigned TDATA_W = 40;

    // Six-dot patterns for a..z, bit i is dot i+1
    localparam logic [5:0] LETTER_DOTS [26] = '{
        6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
        6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
        6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
    };

    typedef struct packed {
        logic       shown;
        logic [5:0] dots;
    } cell_t;

    // Printable usage code to ASCII, CH_NONE when not printable
    function automatic logic [6:0] code_to_char(input logic [7:0] code);
        logic [7:0] tmp;
        tmp = 8'h00;
        if (code >= KEY_A_CODE && code <= KEY_Z_CODE) begin
            tmp = code - KEY_A_CODE + {1'b0, CH_LC_A};
        end else if (code >= KEY_1_CODE && code <= KEY_9_CODE) begin
            tmp = code - KEY_1_CODE + {1'b0, CH_ONE};
        end else if (code == KEY_0_CODE) begin
            tmp = {1'b0, CH_ZERO};
        end else if (code == KEY_SPACE_CODE) begin
            tmp = {1'b0, CH_SPACE};
        end
        return tmp[6:0];
    endfunction

    // ASCII to braille cell; digits reuse a..j
    function automatic cell_t char_to_cell(input logic [6:0] ch);
        cell_t      c;
        logic [6:0] idx;
        c   = '0;
        idx = 7'd0;
        if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
            idx     = ch - CH_LC_A;
            c.dots  = LETTER_DOTS[idx[4:0]];
            c.shown = 1'b1;
        end else if (ch >= CH_ONE && ch <= CH_NINE) begin
            idx     = ch - CH_ONE;
            c.dots  = LETTER_DOTS[idx[4:0]];
            c.shown = 1'b1;
        end else if (ch == CH_ZERO) begin
            c.dots  = LETTER_DOTS[9];
            c.shown = 1'b1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/keyboard_line_to_braille_cell_top.sv -----
// Top level of the keyboard line to braille cell block.
// Depends on kbc_pkg (codes, sizes, braille lookup).
//
// Usage:
//   Input channel s_*: one item per keyboard event. s_tuser[1:0] is the
//   command (key code, advance press, return press), s_tdata[7:0] the
//   keyboard usage code, looked at only for key commands. Letters, digits
//   and space are appended to the edit line, backspace drops the last
//   character, enter commits the edit line to the display line and homes
//   the cursor. The buttons move the cursor within the display line.
//   Result channel m_*: one item per input item, giving the braille cell,
//   the ASCII character under the cursor and the three line counters.
//   Flow: an accepted item passes the input register, then the store read and
//   result register; one item per cycle sustained while m_tready stays high.
//   Character store: 256 x 7 bit memory, one write port (edit bank) and one
//   registered read port (display bank), banks swap on commit.
//   Reset: counters, cursor and bank select clear, both stages empty; the
//   store is not cleared, as only written entries are ever shown.
//   Stall: while m_tready is low the result holds, the input register holds
//   one more item and s_tready drops once both are occupied.
`default_nettype none

module keyboard_line_to_braille_cell_top (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [7:0]                   s_tdata,   // [7:0] usage_code
    input  wire  [1:0]                   s_tuser,   // [1:0] cmd
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [5:0] cell_dots, [6] cell_shown, [13:7] shown_char, [20:14] cursor_pos,
    // [27:21] shown_length, [34:28] edit_length, [39:35] zero
    output logic [kbc_pkg::TDATA_W-1:0]  m_tdata
);

    localparam int unsigned CW = kbc_pkg::COUNT_W;
    localparam int unsigned AW = kbc_pkg::ADDR_W;

    // Input register
    logic        a_valid_reg;
    logic [1:0]  a_cmd_reg;
    logic [7:0]  a_code_reg;

    // Result stage; the state registers below also hold the reported counts
    logic        b_valid_reg;
    logic [kbc_pkg::CHAR_W-1:0] rd_q_reg;

    // Line state
    logic          edit_bank_reg,   edit_bank_next;
    logic [CW-1:0] typed_count_reg, typed_count_next;
    logic [CW-1:0] disp_count_reg,  disp_count_next;
    logic [CW-1:0] cursor_reg,      cursor_next;

    // Character store
    logic [kbc_pkg::CHAR_W-1:0] line_mem [kbc_pkg::MEM_DEPTH];
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [kbc_pkg::CHAR_W-1:0] wr_char;
    logic [AW-1:0]              rd_addr;

    logic           advance;
    logic [6:0]     typed_char;
    logic [6:0]     cur_char;
    kbc_pkg::cell_t cur_cell;

    // Item moves from input register into result stage
    assign advance  = a_valid_reg && (!b_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;

    assign typed_char = kbc_pkg::code_to_char(a_code_reg);

    // Effect of the item in the input register
    always_comb begin
        edit_bank_next   = edit_bank_reg;
        typed_count_next = typed_count_reg;
        disp_count_next  = disp_count_reg;
        cursor_next      = cursor_reg;
        wr_en            = 1'b0;
        wr_addr          = {edit_bank_reg, typed_count_reg};
        wr_char          = typed_char;
        unique case (a_cmd_reg)
            kbc_pkg::CMD_KEY: begin
                if (a_code_reg == kbc_pkg::KEY_ENTER_CODE) begin
                    disp_count_next  = typed_count_reg;
                    edit_bank_next   = !edit_bank_reg;
                    typed_count_next = '0;
                    cursor_next      = '0;
                end else if (a_code_reg == kbc_pkg::KEY_BKSP_CODE) begin
                    if (typed_count_reg != '0) begin
                        typed_count_next = typed_count_reg - 1'b1;
                    end
                end else if (typed_char != kbc_pkg::CH_NONE &&
                             typed_count_reg < kbc_pkg::CAPACITY) begin
                    wr_en            = advance;
                    typed_count_next = typed_count_reg + 1'b1;
                end
            end
            kbc_pkg::CMD_ADVANCE: begin
                if (cursor_reg < disp_count_reg) begin
                    cursor_next = cursor_reg + 1'b1;
                end
            end
            kbc_pkg::CMD_RETURN: begin
                if (cursor_reg != '0) begin
                    cursor_next = cursor_reg - 1'b1;
                end
            end
            default: begin
                // unused command, report only
            end
        endcase
        // display bank is the one not being typed into
        rd_addr = {!edit_bank_next, cursor_next};
    end

    // Write into edit bank, read from display bank; never the same bank
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_char;
        end
        if (advance) begin
            rd_q_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            edit_bank_reg   <= 1'b0;
            typed_count_reg <= '0;
            disp_count_reg  <= '0;
            cursor_reg      <= '0;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (advance) begin
                b_valid_reg     <= 1'b1;
                edit_bank_reg   <= edit_bank_next;
                typed_count_reg <= typed_count_next;
                disp_count_reg  <= disp_count_next;
                cursor_reg      <= cursor_next;
            end else if (m_tready) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_cmd_reg  <= s_tuser;
            a_code_reg <= s_tdata;
        end
    end

    // Cursor at line end shows nothing
    assign cur_char = (cursor_reg < disp_count_reg) ? rd_q_reg : kbc_pkg::CH_NONE;
    assign cur_cell = kbc_pkg::char_to_cell(cur_char);

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {5'd0, typed_count_reg, disp_count_reg, cursor_reg,
                       cur_char, cur_cell.shown, cur_cell.dots};

    // Checks
    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= disp_count_reg)
        else $error("cursor beyond display line");

    a_typed_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        typed_count_reg <= kbc_pkg::CAPACITY)
        else $error("edit line over capacity");

    a_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && a_cmd_reg == kbc_pkg::CMD_KEY &&
         a_code_reg == kbc_pkg::KEY_ENTER_CODE)
        |=> (cursor_reg == '0 && typed_count_reg == '0 &&
             edit_bank_reg != $past(edit_bank_reg)))
        else $error("commit did not swap banks and clear edit line");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && b_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both stages full");

endmodule

`default_nettype wire
